>>> sv/affine_dequantize_to_float32_unit_macros.svh
// Assertion macros shared by the dequantizer RTL.
// Depends on signals named clk and rst in the module that uses them.
`ifndef AFFINE_DEQUANTIZE_TO_FLOAT32_UNIT_MACROS_SVH
`define AFFINE_DEQUANTIZE_TO_FLOAT32_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ADQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/adq_pkg.sv
// Package for the affine dequantizer: codes, pipeline types and helper functions.
// No dependencies.
package adq_pkg;

  // Element type codes.
  localparam logic [2:0] ET_F32   = 3'd0;
  localparam logic [2:0] ET_F16   = 3'd1;
  localparam logic [2:0] ET_S8    = 3'd2;
  localparam logic [2:0] ET_U8    = 3'd3;
  localparam logic [2:0] ET_S16   = 3'd4;
  localparam logic [2:0] ET_U16   = 3'd5;
  localparam logic [2:0] ET_S32   = 3'd6;
  localparam logic [2:0] ET_UNSUP = 3'd7;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO      = 2'd2;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] ONE_F32   = 32'h3F80_0000;

  // Decoded scale factor; a finite scale is man * 2^(ex-23) with man[23] set.
  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic signed [9:0]  ex;
    logic [23:0]        man;
  } scl_t;

  // Float difference: value is man * 2^(ex-23), zero when zero is set.
  typedef struct packed {
    logic        zero;
    logic        sign;
    logic [5:0]  ex;
    logic [23:0] man;
  } dfp_t;

  // Request state handed to the multiply and round stages.
  typedef struct packed {
    logic        bypass;
    logic [31:0] byp_val;
    logic        status;
    logic        last;
    dfp_t        d;
    scl_t        scl;
  } mul_in_t;

  // Leading zero count of a 33-bit word; 33 for zero.
  function automatic logic [5:0] lzc33(input logic [32:0] v);
    logic [5:0] cnt;
    cnt = 6'd33;
    for (int k = 0; k < 33; k++) begin
      if (v[k]) cnt = 6'(32 - k);
    end
    return cnt;
  endfunction

  // Rounds an integer magnitude to 24 significant bits, nearest even.
  function automatic dfp_t to_fp(input logic [32:0] mag);
    logic [5:0]  z;
    logic [32:0] n;
    logic        inc;
    logic [24:0] sum;
    dfp_t        r;
    z   = lzc33(mag);
    n   = mag << z;
    inc = n[8] & ((|n[7:0]) | n[9]);
    sum = {1'b0, n[32:9]} + {24'd0, inc};
    r.zero = (mag == 33'd0);
    r.sign = 1'b0;
    if (sum[24]) begin
      r.man = sum[24:1];
      r.ex  = 6'd33 - z;
    end else begin
      r.man = sum[23:0];
      r.ex  = 6'd32 - z;
    end
    return r;
  endfunction

  // Rounds a 32-bit magnitude to the nearest binary32 value, kept as an integer.
  function automatic logic [32:0] round_mag32(input logic [31:0] m);
    logic [5:0]  z;
    logic [32:0] n;
    logic        inc;
    logic [24:0] sum;
    logic [33:0] t;
    z   = lzc33({1'b0, m});
    n   = {1'b0, m} << z;
    inc = n[8] & ((|n[7:0]) | n[9]);
    sum = {1'b0, n[32:9]} + {24'd0, inc};
    t   = {sum, 9'd0} >> z;
    return t[32:0];
  endfunction

  // Exact widening of binary16 bits to binary32 bits.
  function automatic logic [31:0] half_widen(input logic [15:0] h);
    logic        sign;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  sh;
    logic [10:0] nm;
    logic [31:0] r;
    sign = h[15];
    ex   = h[14:10];
    man  = h[9:0];
    sh   = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (man[k]) sh = 4'(10 - k);
    end
    nm = {1'b0, man} << sh;
    if (ex == 5'h1F) begin
      r = {sign, 8'hFF, man, 13'd0};
    end else if (ex == 5'd0) begin
      if (man == 10'd0) r = {sign, 31'd0};
      else r = {sign, 8'd113 - {4'd0, sh}, nm[9:0], 13'd0};
    end else begin
      r = {sign, {3'd0, ex} + 8'd112, man, 13'd0};
    end
    return r;
  endfunction

  // Decodes scale bits; a zero scale of either sign decodes as 1.0.
  function automatic scl_t decode_scale(input logic [31:0] b);
    logic [5:0]  lz;
    logic [23:0] sm;
    scl_t        r;
    lz = lzc33({10'd0, b[22:0]}) - 6'd10;
    sm = 24'({1'b0, b[22:0]} << (lz + 6'd1));
    r.sign = b[31];
    r.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    r.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (b[30:0] == 31'd0) begin
      r.sign = 1'b0;
      r.ex   = 10'sd0;
      r.man  = 24'h80_0000;
    end else if (b[30:23] == 8'd0) begin
      r.ex  = -10'sd127 - $signed({4'd0, lz});
      r.man = sm;
    end else begin
      r.ex  = $signed({2'd0, b[30:23]}) - 10'sd127;
      r.man = {1'b1, b[22:0]};
    end
    return r;
  endfunction

endpackage

>>> sv/adq_elem_if.sv
// Element request channel of the dequantizer.
// Depends on nothing.
interface adq_elem_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_element;
  logic        last_element;
  modport source (output valid, raw_element, last_element, input ready);
  modport sink (input valid, raw_element, last_element, output ready);
endinterface

>>> sv/adq_result_if.sv
// Result request channel of the dequantizer.
// Depends on nothing.
interface adq_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic        status;
  logic        last_out;
  modport source (output valid, value_bits, status, last_out, input ready);
  modport sink (input valid, value_bits, status, last_out, output ready);
endinterface

>>> sv/adq_cfg_if.sv
// Configuration write channel of the dequantizer.
// Depends on adq_pkg for the index width.
interface adq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [adq_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/adq_scale_mul.sv
// Scale multiply and binary32 rounding stages, ending in the result register.
// Depends on adq_pkg.
module adq_scale_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  adq_pkg::mul_in_t  in_req,
  output logic              out_valid,
  output logic [31:0]       value_bits,
  output logic              status,
  output logic              last_out
);

  // Multiply stage registers.
  logic              v3;
  logic [47:0]       prod;
  logic signed [9:0] pex;
  logic              psign;
  logic              use_prod;
  logic [31:0]       fixed_val;
  logic              st3;
  logic              last3;

  // Specials are settled before the multiply result is known.
  logic [31:0] fixed_next;
  logic        sgn;
  always_comb begin
    sgn = in_req.d.sign ^ in_req.scl.sign;
    if (in_req.bypass) begin
      fixed_next = in_req.byp_val;
    end else if (in_req.scl.nan || (in_req.scl.inf && in_req.d.zero)) begin
      fixed_next = adq_pkg::CANON_NAN;
    end else if (in_req.scl.inf) begin
      fixed_next = {sgn, 8'hFF, 23'd0};
    end else begin
      fixed_next = {sgn, 31'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= in_req.d.man * in_req.scl.man;
      pex       <= $signed({4'd0, in_req.d.ex}) + in_req.scl.ex;
      psign     <= sgn;
      use_prod  <= !in_req.bypass && !in_req.scl.nan && !in_req.scl.inf && !in_req.d.zero;
      fixed_val <= fixed_next;
      st3       <= in_req.status;
      last3     <= in_req.last;
    end
  end

  // Normalize, handle underflow to subnormal and overflow, round to nearest even.
  logic        top;
  logic [47:0] nrm;
  logic [10:0] be;
  logic [10:0] shw;
  logic [5:0]  sh;
  logic [47:0] shifted;
  logic        lost;
  logic [23:0] keep;
  logic        gbit;
  logic        sticky;
  logic [7:0]  efield;
  logic        inc;
  logic [30:0] mag;
  logic [31:0] prod_val;
  always_comb begin
    top = prod[47];
    nrm = top ? prod : {prod[46:0], 1'b0};
    be  = {pex[9], pex} + {10'd0, top} + 11'd127;
    shw = 11'd1 - be;
    sh  = (shw[10:6] != 5'd0) ? 6'd48 : shw[5:0];
    if (!be[10] && (be[9:0] != 10'd0)) begin
      shifted = nrm;
      lost    = 1'b0;
      efield  = be[7:0];
    end else begin
      shifted = nrm >> sh;
      lost    = |(nrm & ((48'd1 << sh) - 48'd1));
      efield  = 8'd0;
    end
    keep   = shifted[47:24];
    gbit   = shifted[23];
    sticky = (|shifted[22:0]) | lost;
    inc    = gbit & (sticky | keep[0]);
    mag    = {efield, keep[22:0]} + {30'd0, inc};
    if (!be[10] && (be[9:0] >= 10'd255)) prod_val = {psign, 8'hFF, 23'd0};
    else prod_val = {psign, mag};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_bits <= use_prod ? prod_val : fixed_val;
      status     <= st3;
      last_out   <= last3;
    end
  end

endmodule

>>> sv/affine_dequantize_to_float32_unit.sv
// Affine dequantizer to binary32. Takes one element request per cycle and returns
// one result per request: an accepted request passes the stage one, stage two and
// multiply stage registers before it is loaded into the result register.
// A result that waits at the output holds the whole four-stage pipeline, so the
// sustained rate is one item per cycle whenever the result side is ready.
// Configuration writes are taken in every cycle and must only arrive while no
// request is in flight.
module affine_dequantize_to_float32_unit (
  input logic        clk,
  input logic        rst,
  adq_elem_if.sink   elem,
  adq_result_if.source result,
  adq_cfg_if.sink    cfg
);

  `include "affine_dequantize_to_float32_unit_macros.svh"

  // Configuration registers; the scale is kept in decoded form.
  logic [2:0]        elem_type;
  adq_pkg::scl_t     scl;
  logic [31:0]       zero_offset;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_type   <= adq_pkg::ET_F32;
      scl         <= adq_pkg::decode_scale(adq_pkg::ONE_F32);
      zero_offset <= 32'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        adq_pkg::CFG_ELEM_TYPE: elem_type   <= cfg.data[2:0];
        adq_pkg::CFG_SCALE:     scl         <= adq_pkg::decode_scale(cfg.data);
        adq_pkg::CFG_ZERO:      zero_offset <= cfg.data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the result register is free or being taken.
  logic en;
  assign en         = !result.valid || result.ready;
  assign elem.ready = en;

  // Stage one: operand selection, with int32 operands rounded to float values.
  logic        byp_next;
  logic [31:0] bval_next;
  logic        st_next;
  logic [33:0] a_next;
  logic [33:0] b_next;
  logic [31:0] raw;
  logic [31:0] raw_mag;
  logic [31:0] zp_mag;
  logic [32:0] raw_rnd;
  logic [32:0] zp_rnd;
  always_comb begin
    raw       = elem.raw_element;
    raw_mag   = raw[31] ? (32'd0 - raw) : raw;
    zp_mag    = zero_offset[31] ? (32'd0 - zero_offset) : zero_offset;
    raw_rnd   = adq_pkg::round_mag32(raw_mag);
    zp_rnd    = adq_pkg::round_mag32(zp_mag);
    byp_next  = 1'b0;
    bval_next = 32'd0;
    st_next   = 1'b0;
    a_next    = 34'd0;
    b_next    = {{2{zero_offset[31]}}, zero_offset};
    case (elem_type)
      adq_pkg::ET_F32: begin
        byp_next  = 1'b1;
        bval_next = raw;
      end
      adq_pkg::ET_F16: begin
        byp_next  = 1'b1;
        bval_next = adq_pkg::half_widen(raw[15:0]);
      end
      adq_pkg::ET_S8:  a_next = {{26{raw[7]}}, raw[7:0]};
      adq_pkg::ET_U8:  a_next = {26'd0, raw[7:0]};
      adq_pkg::ET_S16: a_next = {{18{raw[15]}}, raw[15:0]};
      adq_pkg::ET_U16: a_next = {18'd0, raw[15:0]};
      adq_pkg::ET_S32: begin
        a_next = raw[31] ? (34'd0 - {1'b0, raw_rnd}) : {1'b0, raw_rnd};
        b_next = zero_offset[31] ? (34'd0 - {1'b0, zp_rnd}) : {1'b0, zp_rnd};
      end
      default: begin
        byp_next = 1'b1;
        st_next  = 1'b1;
      end
    endcase
  end

  logic        v1;
  logic        byp1;
  logic [31:0] bval1;
  logic        st1;
  logic        last1;
  logic [33:0] a1;
  logic [33:0] b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= elem.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp1  <= byp_next;
      bval1 <= bval_next;
      st1   <= st_next;
      last1 <= elem.last_element;
      a1    <= a_next;
      b1    <= b_next;
    end
  end

  // Stage two: exact difference, rounded once to binary32 precision.
  logic [33:0]      diff;
  logic [33:0]      dmag;
  adq_pkg::dfp_t    dfp;
  adq_pkg::mul_in_t m2_next;
  always_comb begin
    diff     = a1 - b1;
    dmag     = diff[33] ? (34'd0 - diff) : diff;
    dfp      = adq_pkg::to_fp(dmag[32:0]);
    dfp.sign = diff[33];
    m2_next.bypass  = byp1;
    m2_next.byp_val = bval1;
    m2_next.status  = st1;
    m2_next.last    = last1;
    m2_next.d       = dfp;
    m2_next.scl     = scl;
  end

  logic             v2;
  adq_pkg::mul_in_t m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2 <= m2_next;
    end
  end

  // Stages three and four: scale multiply, rounding and the result register.
  adq_scale_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (v2),
    .in_req     (m2),
    .out_valid  (result.valid),
    .value_bits (result.value_bits),
    .status     (result.status),
    .last_out   (result.last_out)
  );

  // Checks on the pipeline control and error reporting.
  `ADQ_ASSERT_IMP(a_err_zero, result.valid && result.status, result.value_bits == 32'd0,
                  "error result carries nonzero value")
  `ADQ_ASSERT_NXT(a_s1_adv, v1 && en, v2, "stage one request lost")
  `ADQ_ASSERT_NXT(a_s2_hold, v2 && !en, v2, "stage two request dropped while stalled")
  `ADQ_ASSERT_NXT(a_unsup, elem.valid && elem.ready && elem_type == adq_pkg::ET_UNSUP,
                  v1 && st1, "unsupported type not flagged")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the affine dequantizer: random and directed element requests
// with a bit-exact binary32 predictor kept in a small scoreboard class.
// Depends on adq_pkg, the three channel interfaces and affine_dequantize_to_float32_unit.
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 10;

  typedef struct {
    logic [31:0] value_bits;
    logic        status;
    logic        last_out;
  } dequant_result_t;

  // Scoreboard: holds the dequantizer settings and the queue of predicted results.
  class dequant_scoreboard;
    logic [2:0]      elem_type;
    logic [31:0]     scale_bits;
    logic [31:0]     zero_offset;
    dequant_result_t pending[$];
    int              mismatches;

    function void reset_settings();
      elem_type   = adq_pkg::ET_F32;
      scale_bits  = adq_pkg::ONE_F32;
      zero_offset = 32'd0;
      mismatches  = 0;
    endfunction

    function void write_setting(logic [adq_pkg::CFG_IDX_W-1:0] index, logic [31:0] data);
      if (index == adq_pkg::CFG_ELEM_TYPE) elem_type = data[2:0];
      else if (index == adq_pkg::CFG_SCALE) scale_bits = data;
      else if (index == adq_pkg::CFG_ZERO) zero_offset = data;
    endfunction

    // Rounds an integer to 24 significant bits, nearest even.
    function longint round_to_single(longint v);
      longint unsigned mag;
      longint unsigned kept;
      int              msb;
      int              sh;
      logic            guard;
      logic            sticky;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      if (mag < 64'd16777216) return v;
      msb = 0;
      for (int k = 0; k < 64; k++) if (mag[k]) msb = k;
      sh     = msb - 23;
      kept   = mag >> sh;
      guard  = mag[sh-1];
      sticky = (sh > 1) && ((mag & ((64'd1 << (sh - 1)) - 64'd1)) != 0);
      if (guard && (sticky || kept[0])) kept++;
      kept = kept << sh;
      return (v < 0) ? -longint'(kept) : longint'(kept);
    endfunction

    // Multiplies an integer valued float by the scale, rounding once to binary32.
    function logic [31:0] scale_product(longint d, logic [31:0] sbits);
      logic            sgn;
      int              ef;
      int              e2;
      int              msb;
      int              e;
      int              lsb;
      int              sh;
      longint unsigned mag;
      longint unsigned m;
      longint unsigned prod;
      longint unsigned kept;
      logic            guard;
      logic            sticky;
      // A zero scale of either sign stands for 1.0.
      if (sbits[30:0] == 31'd0) sbits = adq_pkg::ONE_F32;
      sgn = (d < 0) ^ sbits[31];
      ef  = int'(sbits[30:23]);
      if (ef == 255) begin
        if (sbits[22:0] != 23'd0 || d == 0) return adq_pkg::CANON_NAN;
        return {sgn, 8'hFF, 23'd0};
      end
      if (d == 0) return {sgn, 31'd0};
      mag = (d < 0) ? longint'(-d) : longint'(d);
      if (ef == 0) begin
        m  = {41'd0, sbits[22:0]};
        e2 = -149;
      end else begin
        m  = {40'd0, 1'b1, sbits[22:0]};
        e2 = ef - 150;
      end
      prod = mag * m;
      msb  = 0;
      for (int k = 0; k < 64; k++) if (prod[k]) msb = k;
      e = msb + e2;
      if (e > 127) return {sgn, 8'hFF, 23'd0};
      lsb = (e >= -126) ? e - 23 : -149;
      sh  = lsb - e2;
      if (sh <= 0) begin
        kept = prod << (-sh);
      end else if (sh > 64) begin
        kept = 64'd0;
      end else begin
        kept   = (sh == 64) ? 64'd0 : prod >> sh;
        guard  = prod[sh-1];
        sticky = (sh > 1) && ((prod & ((64'd1 << (sh - 1)) - 64'd1)) != 0);
        if (guard && (sticky || kept[0])) kept++;
      end
      if (kept == 64'd16777216) begin
        kept = kept >> 1;
        lsb++;
      end
      if (kept >= 64'd8388608) begin
        if (lsb + 150 >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, 8'(lsb + 150), kept[22:0]};
      end
      return {sgn, 8'd0, kept[22:0]};
    endfunction

    // Exact widening of half precision bits.
    function logic [31:0] widen_half(logic [15:0] h);
      logic [9:0] man;
      int         e;
      man = h[9:0];
      if (h[14:10] == 5'h1F) return {h[15], 8'hFF, man, 13'd0};
      if (h[14:10] != 5'd0) return {h[15], 8'(int'(h[14:10]) + 112), man, 13'd0};
      if (man == 10'd0) return {h[15], 31'd0};
      e = 113;
      while (man[9] == 1'b0) begin
        man = man << 1;
        e--;
      end
      man = man << 1;
      return {h[15], 8'(e - 1), man, 13'd0};
    endfunction

    // Predicts the result of one accepted element request.
    function void note_request(logic [31:0] raw, logic last);
      dequant_result_t r;
      longint          zp;
      longint          q;
      zp = longint'($signed(zero_offset));
      r.value_bits = 32'd0;
      r.status     = 1'b0;
      r.last_out   = last;
      case (elem_type) inside
        adq_pkg::ET_F32: r.value_bits = raw;
        adq_pkg::ET_F16: r.value_bits = widen_half(raw[15:0]);
        adq_pkg::ET_S8, adq_pkg::ET_U8, adq_pkg::ET_S16, adq_pkg::ET_U16: begin
          if (elem_type == adq_pkg::ET_S8) q = longint'($signed(raw[7:0]));
          else if (elem_type == adq_pkg::ET_U8) q = longint'(raw[7:0]);
          else if (elem_type == adq_pkg::ET_S16) q = longint'($signed(raw[15:0]));
          else q = longint'(raw[15:0]);
          r.value_bits = scale_product(round_to_single(q - zp), scale_bits);
        end
        adq_pkg::ET_S32: begin
          q = round_to_single(longint'($signed(raw))) - round_to_single(zp);
          r.value_bits = scale_product(round_to_single(q), scale_bits);
        end
        default: r.status = 1'b1;
      endcase
      pending.push_back(r);
    endfunction

    // Compares one accepted result against the oldest prediction.
    function void check_result(logic [31:0] value_bits, logic status, logic last_out);
      dequant_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h status %b last %b",
                   value_bits, status, last_out);
        return;
      end
      want = pending.pop_front();
      if (want.value_bits !== value_bits || want.status !== status
          || want.last_out !== last_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h/%b/%b got %h/%b/%b",
                   want.value_bits, want.status, want.last_out,
                   value_bits, status, last_out);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic quiet;
  int   idle_count;
  dequant_scoreboard sb;

  adq_elem_if   elem ();
  adq_result_if result ();
  adq_cfg_if    cfg ();

  affine_dequantize_to_float32_unit dut (
    .clk    (clk),
    .rst    (rst),
    .elem   (elem.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Monitors: sample every handshake at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.write_setting(cfg.index, cfg.data);
      if (elem.valid && elem.ready) sb.note_request(elem.raw_element, elem.last_element);
      if (result.valid && result.ready)
        sb.check_result(result.value_bits, result.status, result.last_out);
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk) begin
    if (rst || (elem.valid && elem.ready) || (result.valid && result.ready)
        || (cfg.valid && cfg.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Result side backpressure.
  always @(negedge clk) begin
    result.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 28);
  end

  // Sends one element request, with random idle cycles ahead of it.
  task automatic send_element(logic [31:0] raw, logic last);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 28) begin
      elem.valid = 1'b0;
      @(negedge clk);
    end
    elem.valid        = 1'b1;
    elem.raw_element  = raw;
    elem.last_element = last;
    do @(posedge clk); while (!elem.ready);
  endtask

  // Writes one register once the pipeline has drained.
  task automatic write_register(logic [adq_pkg::CFG_IDX_W-1:0] index, logic [31:0] data);
    @(negedge clk);
    elem.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = index;
    cfg.data  = data;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic apply_settings(logic [2:0] et, logic [31:0] scale, logic [31:0] zp);
    write_register(adq_pkg::CFG_ELEM_TYPE, {29'd0, et});
    write_register(adq_pkg::CFG_SCALE, scale);
    write_register(adq_pkg::CFG_ZERO, zp);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return {1'b0, 8'hFF, 23'($urandom_range(1, 8388607))};
      5: return {31'd0, 1'b1} << $urandom_range(22);
      6: return 32'h7F7F_FFFF;
      7: return $urandom();
      default: return {1'($urandom_range(1)), 8'($urandom_range(100, 150)),
                       23'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] pick_zero();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom();
      default: return 32'($signed($urandom_range(600)) - 300);
    endcase
  endfunction

  // Random element bits: mostly full width, some small, some equal to the zero point.
  task automatic send_random(int count);
    logic [31:0] raw;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(19))
        0, 1, 2: raw = 32'($signed($urandom_range(512)) - 256);
        3, 4:    raw = sb.zero_offset;
        default: raw = $urandom();
      endcase
      send_element(raw, (k == count - 1) || ($urandom_range(15) == 0));
    end
  endtask

  initial begin
    logic [31:0] corner[3];
    sb = new();
    sb.reset_settings();
    quiet             = 1'b0;
    rst               = 1'b1;
    elem.valid        = 1'b0;
    elem.raw_element  = 32'd0;
    elem.last_element = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = adq_pkg::CFG_ELEM_TYPE;
    cfg.data          = 32'd0;
    result.ready      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, then every element type on field extremes.
    corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_7C01};
    for (int t = 0; t < 8; t++) begin
      if (t != 0) apply_settings(3'(t), 32'h3F80_0000, 32'h0000_0001);
      for (int k = 0; k < 3; k++) send_element(corner[k], k[0]);
    end
    apply_settings(adq_pkg::ET_F16, adq_pkg::ONE_F32, 32'd0);
    send_element(32'h0000_FE01, 1'b0);
    send_element(32'h0000_0001, 1'b1);

    // Directed extremes of the settings: wide differences, tiny and huge scales.
    apply_settings(adq_pkg::ET_S32, 32'h7F7F_FFFF, 32'h8000_0000);
    send_random(20);
    apply_settings(adq_pkg::ET_S32, 32'h0000_0001, 32'h7FFF_FFFF);
    send_random(20);
    apply_settings(adq_pkg::ET_U16, 32'h8000_0000, 32'h8000_0000);
    send_random(20);
    apply_settings(adq_pkg::ET_S8, 32'hFF80_0000, 32'h0000_0000);
    send_random(20);
    apply_settings(adq_pkg::ET_S16, 32'h7FC0_0001, 32'h7FFF_FFFF);
    send_random(20);

    // Random settings; one phase runs with no idling on either side.
    for (int p = 0; p < 36; p++) begin
      apply_settings(3'($urandom_range(7)), pick_scale(), pick_zero());
      quiet = (p == 12);
      send_random(30);
    end
    quiet = 1'b0;

    @(negedge clk);
    elem.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/adq_pkg.sv
sv/adq_elem_if.sv
sv/adq_result_if.sv
sv/adq_cfg_if.sv
sv/adq_scale_mul.sv
sv/affine_dequantize_to_float32_unit.sv
bench/tb_top.sv
